[hw/rtl/uqps_pkg.sv]
// Package with the phase, result kind types and character codes of the URL query pair splitter.
package uqps_pkg;

  typedef enum logic [2:0] {
    PH_SEEK_COLON = 3'd0,
    PH_COLON      = 3'd1,
    PH_COLON_SL   = 3'd2,
    PH_SEEK_SLASH = 3'd3,
    PH_SEEK_QUERY = 3'd4,
    PH_NAME       = 3'd5,
    PH_VALUE      = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_VALUE   = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_ABANDON = 2'd3
  } kind_t;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUERY = 8'h3f;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_AMP   = 8'h26;

endpackage

[hw/rtl/url_query_pair_splitter_core.sv]
// Top level of the URL query pair splitter: byte parser with a registered result stage.
//
// The slave stream takes one URL byte per item on s_axis_tdata; a zero byte ends the URL
// and returns the parser to its start state. The parser finds the first "://", the next
// '/', then the next '?', and splits the query into name=value pairs. Each input item
// gives zero or one result item on the master stream: m_axis_tuser holds the kind
// (name byte, value byte, pair complete, partial name abandoned) and m_axis_tdata the
// byte, zero for the two marker kinds. A pair with an empty name gives no result items.
// An accepted byte's result is registered and shows in the next cycle. Throughput is one
// byte per cycle unless the receiver stalls, set by the single state update between the
// input and the result register. The block takes a new byte while the result register is
// empty or being drained in the same cycle. When the receiver stalls, the result is
// held and s_axis_tready drops until it is taken. Reset empties the result register and
// puts the parser at the search for the scheme separator with no name seen.
module url_query_pair_splitter_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic [1:0] m_axis_tuser    // [1:0] kind
);
  import uqps_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic       name_seen;
  logic       name_seen_next;
  logic       emit;
  kind_t      emit_kind;
  logic [7:0] emit_byte;
  logic       accept;
  logic       out_valid;
  kind_t      out_kind;
  logic [7:0] out_byte;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tuser  = out_kind;

  always_comb begin
    phase_next     = phase;
    name_seen_next = name_seen;
    emit           = 1'b0;
    emit_kind      = KIND_NAME;
    emit_byte      = 8'h00;
    if (s_axis_tdata == CH_END) begin
      if (phase == PH_NAME && name_seen) begin
        emit      = 1'b1;
        emit_kind = KIND_ABANDON;
      end else if (phase == PH_VALUE && name_seen) begin
        emit      = 1'b1;
        emit_kind = KIND_DONE;
      end
      phase_next     = PH_SEEK_COLON;
      name_seen_next = 1'b0;
    end else begin
      unique case (phase)
        PH_COLON: begin
          if (s_axis_tdata == CH_COLON) phase_next = PH_COLON;
          else if (s_axis_tdata == CH_SLASH) phase_next = PH_COLON_SL;
          else phase_next = PH_SEEK_COLON;
        end
        PH_COLON_SL: begin
          if (s_axis_tdata == CH_COLON) phase_next = PH_COLON;
          else if (s_axis_tdata == CH_SLASH) phase_next = PH_SEEK_SLASH;
          else phase_next = PH_SEEK_COLON;
        end
        PH_SEEK_SLASH: begin
          if (s_axis_tdata == CH_SLASH) phase_next = PH_SEEK_QUERY;
        end
        PH_SEEK_QUERY: begin
          if (s_axis_tdata == CH_QUERY) begin
            phase_next     = PH_NAME;
            name_seen_next = 1'b0;
          end
        end
        PH_NAME: begin
          if (s_axis_tdata == CH_EQUAL) begin
            phase_next = PH_VALUE;
          end else begin
            name_seen_next = 1'b1;
            emit           = 1'b1;
            emit_kind      = KIND_NAME;
            emit_byte      = s_axis_tdata;
          end
        end
        PH_VALUE: begin
          if (s_axis_tdata == CH_AMP) begin
            emit           = name_seen;
            emit_kind      = KIND_DONE;
            phase_next     = PH_NAME;
            name_seen_next = 1'b0;
          end else if (name_seen) begin
            emit      = 1'b1;
            emit_kind = KIND_VALUE;
            emit_byte = s_axis_tdata;
          end
        end
        default: begin
          phase_next = (s_axis_tdata == CH_COLON) ? PH_COLON : PH_SEEK_COLON;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SEEK_COLON;
      name_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        phase     <= phase_next;
        name_seen <= name_seen_next;
        out_valid <= emit;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_kind <= emit_kind;
      out_byte <= emit_byte;
    end
  end

endmodule

[hw/rtl/uqps_checker.sv]
// Port checker for the URL query pair splitter and its bind to the top level.
module uqps_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser
);
  import uqps_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("Stalled result item changed.");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_DONE || m_axis_tuser == KIND_ABANDON) |->
      m_axis_tdata == 8'h00)
    else $error("Marker item carries a nonzero byte.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("Result item present after reset.");

  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("Result item appeared without an accepted input item.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("Input not ready while the result stage is empty.");

endmodule

bind url_query_pair_splitter_core uqps_checker u_uqps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
